// File: sv/rencb_pkg.sv
// Package for the rotary encoder with push switch block.
// Holds widths, register indexes, the controller state type, the command and
// status structs and the quadrature step table. Depends on nothing.
package rencb_pkg;

   localparam int CSR_IDX_W            = 2;
   localparam int CSR_DATA_W           = 17;
   localparam int DEBOUNCE_W           = 10;
   localparam int DIVISOR_W            = 8;
   localparam int ROT_W                = 17;
   localparam int COUNT_W              = 32;
   localparam int QUO_W                = 48;
   localparam int SCALE_MUL_W          = 16;
   localparam int DETENTS_PER_TURN     = 20;
   localparam int DEN_W                = 16 + $clog2(DETENTS_PER_TURN + 1);
   localparam int EDGE_TIMER_BITS_DEF  = 10;
   localparam int DIV1_STEPS           = 16;
   localparam int DIV2_STEPS           = 24;
   localparam int CNT_W                = 5;

   localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 16'd65280;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd20;
   localparam logic [DIVISOR_W-1:0]  DIVISOR_RST  = 8'd4;
   localparam logic [ROT_W-1:0]      ROT_RST      = 17'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT      = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DET_SETUP,
      S_DET_DIV,
      S_DET_DONE,
      S_MUL,
      S_SCL_LOAD,
      S_SCL_DIV,
      S_SCL_DONE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic step;
      logic det_pass;
      logic div1_load;
      logic div_step;
      logic det_take;
      logic scale_pass;
      logic mul;
      logic div2_load;
      logic scale_take;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_zero;
      logic rot_off;
   } status_type;

   // Quadrature step for the previous AB pair (high two bits) and current pair.
   function automatic logic signed [1:0] step_delta(input logic [3:0] idx);
      logic signed [1:0] d;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

// File: sv/rencb_ctrl.sv
// Controller of the rotary encoder block: sequences the per-sample update,
// both divisions and the result transfer. Depends on rencb_pkg.
module rencb_ctrl
   import rencb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = S_DET_SETUP;
            end
         end
         S_DET_SETUP: begin
            if (status.div_zero) begin
               cmd.det_pass = 1'b1;
               state_in     = S_MUL;
            end else begin
               cmd.div1_load = 1'b1;
               cnt_in        = CNT_W'(DIV1_STEPS - 1);
               state_in      = S_DET_DIV;
            end
         end
         S_DET_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DET_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DET_DONE: begin
            cmd.det_take = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            if (status.rot_off) begin
               cmd.scale_pass = 1'b1;
               state_in       = S_OUT;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_SCL_LOAD;
            end
         end
         S_SCL_LOAD: begin
            cmd.div2_load = 1'b1;
            cnt_in        = CNT_W'(DIV2_STEPS - 1);
            state_in      = S_SCL_DIV;
         end
         S_SCL_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_SCL_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_SCL_DONE: begin
            cmd.scale_take = 1'b1;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // A waiting result is never overwritten before its transfer.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while waiting");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DET_SETUP))
      else $error("accepted sample did not start processing");

   a_div1_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DET_DIV && $past(state_ff) == S_DET_SETUP)
         |-> (cnt_ff == CNT_W'(DIV1_STEPS - 1)))
      else $error("detent division started with a wrong step count");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result valid raised outside the output state");

endmodule

// File: sv/rencb_dp.sv
// Datapath of the rotary encoder block: encoder and switch state, the
// configuration registers, a two-bit-per-cycle divider and the result registers.
// Depends on rencb_pkg.
module rencb_dp
   import rencb_pkg::*;
#(
   parameter int EDGE_TIMER_BITS = EDGE_TIMER_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      req_a_level,
   input  logic                      req_b_level,
   input  logic                      req_switch_level,
   input  logic                      req_ms_tick,
   input  logic                      req_clear_count,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   output logic signed [COUNT_W-1:0] rsp_quarter_count,
   output logic signed [COUNT_W-1:0] rsp_detent_count,
   output logic signed [COUNT_W-1:0] rsp_scaled_count,
   output logic                      rsp_switch_pressed,
   output logic                      rsp_press_event,
   output logic                      rsp_release_event
);

   localparam int CMP_W = (EDGE_TIMER_BITS > DEBOUNCE_W) ? EDGE_TIMER_BITS : DEBOUNCE_W;
   localparam logic [EDGE_TIMER_BITS-1:0] TIMER_MAX = {EDGE_TIMER_BITS{1'b1}};

   // Control and configuration state.
   logic [DEBOUNCE_W-1:0]      debounce_ff, debounce_in;
   logic [DIVISOR_W-1:0]       divisor_ff, divisor_in;
   logic [ROT_W-1:0]           rot_ff, rot_in;
   logic [1:0]                 prev_ab_ff, prev_ab_in;
   logic [COUNT_W-1:0]         total_ff, total_in;
   logic                       last_raw_ff, last_raw_in;
   logic                       stable_ff, stable_in;
   logic [EDGE_TIMER_BITS-1:0] ms_ff, ms_in;

   // Payload registers.
   logic [COUNT_W-1:0] q_ff, q_in;
   logic [COUNT_W-1:0] det_ff, det_in;
   logic [COUNT_W-1:0] scaled_ff, scaled_in;
   logic               press_ff, press_in;
   logic               release_ff, release_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   dsr_ff, dsr_in;
   logic               neg_ff, neg_in;
   logic [QUO_W-1:0]   prod_ff, prod_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [COUNT_W-1:0] out_q_ff, out_q_in;
   logic [COUNT_W-1:0] out_det_ff, out_det_in;
   logic [COUNT_W-1:0] out_scaled_ff, out_scaled_in;
   logic               out_pressed_ff, out_pressed_in;
   logic               out_press_ff, out_press_in;
   logic               out_release_ff, out_release_in;

   logic signed [1:0]  delta;
   logic [COUNT_W-1:0] q_new;
   logic               raw_change;
   logic               accept_level;
   logic [EDGE_TIMER_BITS-1:0] ms_next;
   logic [COUNT_W-1:0] q_mag;
   logic [COUNT_W-1:0] det_mag;
   logic [DEN_W:0]     sh1, sh2;
   logic               ge1, ge2;
   logic [DEN_W-1:0]   r1, r2;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RST;
         divisor_ff  <= DIVISOR_RST;
         rot_ff      <= ROT_RST;
         prev_ab_ff  <= 2'b11;
         total_ff    <= '0;
         last_raw_ff <= 1'b1;
         stable_ff   <= 1'b1;
         ms_ff       <= '0;
      end else begin
         debounce_ff <= debounce_in;
         divisor_ff  <= divisor_in;
         rot_ff      <= rot_in;
         prev_ab_ff  <= prev_ab_in;
         total_ff    <= total_in;
         last_raw_ff <= last_raw_in;
         stable_ff   <= stable_in;
         ms_ff       <= ms_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff           <= q_in;
      det_ff         <= det_in;
      scaled_ff      <= scaled_in;
      press_ff       <= press_in;
      release_ff     <= release_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      dsr_ff         <= dsr_in;
      neg_ff         <= neg_in;
      prod_ff        <= prod_in;
      den_ff         <= den_in;
      out_q_ff       <= out_q_in;
      out_det_ff     <= out_det_in;
      out_scaled_ff  <= out_scaled_in;
      out_pressed_ff <= out_pressed_in;
      out_press_ff   <= out_press_in;
      out_release_ff <= out_release_in;
   end

   // Configuration writes.
   always_comb begin
      debounce_in = debounce_ff;
      divisor_in  = divisor_ff;
      rot_in      = rot_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_in = csr_wdata[DEBOUNCE_W-1:0];
            CSR_DIVISOR:  divisor_in  = csr_wdata[DIVISOR_W-1:0];
            CSR_ROT:      rot_in      = csr_wdata[ROT_W-1:0];
            default: ;
         endcase
      end
   end

   // Per-sample encoder and switch update.
   always_comb begin
      delta      = step_delta({prev_ab_ff, req_a_level, req_b_level});
      q_new      = total_ff + COUNT_W'(delta);
      raw_change = (req_switch_level != last_raw_ff);
      if (raw_change) begin
         ms_next = '0;
      end else if (req_ms_tick && (ms_ff != TIMER_MAX)) begin
         ms_next = ms_ff + 1'b1;
      end else begin
         ms_next = ms_ff;
      end
      accept_level = (req_switch_level != stable_ff)
                     && (CMP_W'(ms_next) >= CMP_W'(debounce_ff));

      prev_ab_in  = prev_ab_ff;
      total_in    = total_ff;
      last_raw_in = last_raw_ff;
      stable_in   = stable_ff;
      ms_in       = ms_ff;
      q_in        = q_ff;
      press_in    = press_ff;
      release_in  = release_ff;
      if (cmd.step) begin
         prev_ab_in  = {req_a_level, req_b_level};
         total_in    = req_clear_count ? '0 : q_new;
         last_raw_in = req_switch_level;
         ms_in       = ms_next;
         q_in        = q_new;
         press_in    = accept_level && !req_switch_level;
         release_in  = accept_level && req_switch_level;
         if (accept_level) begin
            stable_in = req_switch_level;
         end
      end
   end

   assign status.div_zero = (divisor_ff == '0);
   assign status.rot_off  = rot_ff[ROT_W-1] || (rot_ff == '0);

   // Divider, magnitudes, product and saturation.
   always_comb begin
      q_mag   = q_ff[COUNT_W-1] ? (~q_ff + 1'b1) : q_ff;
      det_mag = det_ff[COUNT_W-1] ? (~det_ff + 1'b1) : det_ff;

      sh1 = {rem_ff, quo_ff[QUO_W-1]};
      ge1 = (sh1 >= {1'b0, dsr_ff});
      r1  = ge1 ? DEN_W'(sh1 - {1'b0, dsr_ff}) : sh1[DEN_W-1:0];
      sh2 = {r1, quo_ff[QUO_W-2]};
      ge2 = (sh2 >= {1'b0, dsr_ff});
      r2  = ge2 ? DEN_W'(sh2 - {1'b0, dsr_ff}) : sh2[DEN_W-1:0];

      det_in    = det_ff;
      scaled_in = scaled_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      den_in    = den_ff;

      if (cmd.det_pass) begin
         det_in = q_ff;
      end
      if (cmd.div1_load) begin
         quo_in = {q_mag, {(QUO_W - COUNT_W){1'b0}}};
         rem_in = '0;
         dsr_in = DEN_W'(divisor_ff);
         neg_in = q_ff[COUNT_W-1];
      end
      if (cmd.div_step) begin
         quo_in = {quo_ff[QUO_W-3:0], ge1, ge2};
         rem_in = r2;
      end
      if (cmd.det_take) begin
         det_in = neg_ff ? (~quo_ff[COUNT_W-1:0] + 1'b1) : quo_ff[COUNT_W-1:0];
      end
      if (cmd.scale_pass) begin
         scaled_in = det_ff;
      end
      if (cmd.mul) begin
         prod_in = {{(QUO_W - COUNT_W){1'b0}}, det_mag}
                   * {{(QUO_W - SCALE_MUL_W){1'b0}}, SCALE_MUL};
         den_in  = DEN_W'(rot_ff[ROT_W-2:0]) * DEN_W'(DETENTS_PER_TURN);
         neg_in  = det_ff[COUNT_W-1];
      end
      if (cmd.div2_load) begin
         quo_in = prod_ff;
         rem_in = '0;
         dsr_in = den_ff;
      end
      if (cmd.scale_take) begin
         if (!neg_ff) begin
            if (quo_ff > QUO_W'(32'h7FFF_FFFF)) begin
               scaled_in = 32'h7FFF_FFFF;
            end else begin
               scaled_in = quo_ff[COUNT_W-1:0];
            end
         end else begin
            if (quo_ff > QUO_W'(32'h8000_0000)) begin
               scaled_in = 32'h8000_0000;
            end else begin
               scaled_in = ~quo_ff[COUNT_W-1:0] + 1'b1;
            end
         end
      end
   end

   // Result register.
   always_comb begin
      out_q_in       = out_q_ff;
      out_det_in     = out_det_ff;
      out_scaled_in  = out_scaled_ff;
      out_pressed_in = out_pressed_ff;
      out_press_in   = out_press_ff;
      out_release_in = out_release_ff;
      if (cmd.out_load) begin
         out_q_in       = q_ff;
         out_det_in     = det_ff;
         out_scaled_in  = scaled_ff;
         out_pressed_in = !stable_ff;
         out_press_in   = press_ff;
         out_release_in = release_ff;
      end
   end

   assign rsp_quarter_count  = out_q_ff;
   assign rsp_detent_count   = out_det_ff;
   assign rsp_scaled_count   = out_scaled_ff;
   assign rsp_switch_pressed = out_pressed_ff;
   assign rsp_press_event    = out_press_ff;
   assign rsp_release_event  = out_release_ff;

endmodule

// File: sv/rotary_encoder_with_button.sv
// Rotary encoder decoder (x4 quadrature) with debounced push switch.
// Each request transfer carries one sample of pins A and B, the raw switch
// level, a millisecond tick and a clear command; each sample yields exactly
// one response transfer with the quarter count, the detent count, the scaled
// count and the debounced switch state with press and release events.
// The request channel is ready only while the block is idle. When both
// divisions run, the shared divider retires two quotient bits per cycle,
// first for the detent division and then for the scaling division. A
// zero detent divisor or a non-positive rotations value skips the
// matching division.
// The response sits in an output register; the next sample is accepted while
// it waits, and a stalled receiver only holds the block in its final step.
// Configuration writes are always ready and take effect at once; write them
// only while no sample is in progress. Reset clears the running quarter count,
// assumes both pins high and the switch released, and restores register
// defaults: debounce 20 ms, divisor 4, rotations 1.0.
// Depends on rencb_pkg, rencb_ctrl and rencb_dp.
module rotary_encoder_with_button
   import rencb_pkg::*;
#(
   parameter int EDGE_TIMER_BITS = EDGE_TIMER_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_a_level,
   input  logic                      req_b_level,
   input  logic                      req_switch_level,
   input  logic                      req_ms_tick,
   input  logic                      req_clear_count,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COUNT_W-1:0] rsp_quarter_count,
   output logic signed [COUNT_W-1:0] rsp_detent_count,
   output logic signed [COUNT_W-1:0] rsp_scaled_count,
   output logic                      rsp_switch_pressed,
   output logic                      rsp_press_event,
   output logic                      rsp_release_event,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rencb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rencb_dp #(
      .EDGE_TIMER_BITS (EDGE_TIMER_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_a_level        (req_a_level),
      .req_b_level        (req_b_level),
      .req_switch_level   (req_switch_level),
      .req_ms_tick        (req_ms_tick),
      .req_clear_count    (req_clear_count),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_quarter_count  (rsp_quarter_count),
      .rsp_detent_count   (rsp_detent_count),
      .rsp_scaled_count   (rsp_scaled_count),
      .rsp_switch_pressed (rsp_switch_pressed),
      .rsp_press_event    (rsp_press_event),
      .rsp_release_event  (rsp_release_event)
   );

endmodule
